/* rtl/jdc_pkg.sv */
// ----------------------------------------------------------------------------
// jdc_pkg: shared types, constants and helpers for the Julian day converter
// Request/result words, controller commands and status, calendar helpers.
// ----------------------------------------------------------------------------
package jdc_pkg;

  // Field widths
  localparam int unsigned DN_W   = 23;
  localparam int unsigned DAY_W  = 9;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned ODAY_W = 5;

  // Internal widths
  localparam int unsigned ACC_W   = 24;
  localparam int unsigned YY_W    = 16;
  localparam int unsigned DAYS_W  = 14;
  localparam int unsigned R400_W  = 9;
  localparam int unsigned Q365_W  = 15;
  localparam int unsigned Q100_W  = 8;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned DIV_IN_W = 15;

  // Reciprocal constants for division by 365 and by 100
  localparam int unsigned RECIP365_W  = 25;
  localparam int unsigned RECIP365    = 23534068;
  localparam int unsigned RECIP365_SH = 33;
  localparam int unsigned PROD365_W   = DN_W + RECIP365_W;
  localparam int unsigned RECIP100    = 5243;
  localparam int unsigned RECIP100_SH = 19;
  localparam int unsigned PROD100_W   = 28;

  // Calendar constants
  localparam int JDN_SHIFT      = 2299161 - 577738;
  localparam int CUT_LIMIT      = 577737;
  localparam int CUT_DAYS       = 10;
  localparam int GREG_YEAR      = 1582;
  localparam int CENT_YEAR      = 1700;
  localparam int CENT_ADJ       = 12;
  localparam int YEAR_DAYS      = 365;
  localparam int CYCLE_YEARS    = 400;
  localparam int MONTH_CAP      = 13;
  localparam int LAST_MONTH_IDX = 11;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [YY_W-1:0]   yy_t;
  typedef logic signed [DAYS_W-1:0] days_t;

  typedef struct packed {
    logic              opcode;
    logic [DAY_W-1:0]  in_day;
    logic [MON_W-1:0]  in_month;
    logic [YEAR_W-1:0] in_year;
    logic [DN_W-1:0]   in_day_number;
  } req_t;

  typedef struct packed {
    logic [DN_W-1:0]   out_day_number;
    logic [ODAY_W-1:0] out_day;
    logic [MON_W-1:0]  out_month;
    logic [YEAR_W-1:0] out_year;
    logic [DAY_W-1:0]  out_day_of_year;
  } res_t;

  typedef enum logic [3:0] {
    CMD_NOP       = 4'd0,
    CMD_LOAD      = 4'd1,
    CMD_E_BASE    = 4'd2,
    CMD_E_CENT    = 4'd3,
    CMD_E_LEAP    = 4'd4,
    CMD_MON_ADD   = 4'd5,
    CMD_E_FIN     = 4'd6,
    CMD_D_SHIFT   = 4'd7,
    CMD_D_DIV     = 4'd8,
    CMD_D_REM     = 4'd9,
    CMD_D_QTR     = 4'd10,
    CMD_D_CENT    = 4'd11,
    CMD_YEAR_STEP = 4'd12,
    CMD_YEAR_FIX  = 4'd13,
    CMD_MON_SCAN  = 4'd14
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic mon_last;
    logic days_pos;
    logic scan_done;
  } stat_t;

  function automatic logic [LEN_W-1:0] month_len(logic lp, logic [MON_W-1:0] idx);
    logic [LEN_W-1:0] len;
    case (idx)
      4'd1:    len = lp ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Exact for x below 25600
  function automatic logic [Q100_W-1:0] div100(logic [DIV_IN_W-1:0] x);
    logic [PROD100_W-1:0] p;
    p = PROD100_W'(x) * PROD100_W'(RECIP100);
    return p[RECIP100_SH +: Q100_W];
  endfunction

  function automatic logic [R400_W-1:0] rem400(logic [DIV_IN_W-1:0] x,
                                               logic [Q100_W-1:0] q100);
    logic [DIV_IN_W-1:0] t;
    t = x - DIV_IN_W'(DIV_IN_W'(q100[Q100_W-1:2]) * DIV_IN_W'(CYCLE_YEARS));
    return t[R400_W-1:0];
  endfunction

  // Quotient by four, truncated toward zero
  function automatic yy_t div4_trunc(yy_t x);
    yy_t m;
    m = x[YY_W-1] ? -x : x;
    m = m >>> 2;
    return x[YY_W-1] ? -m : m;
  endfunction

  // early: year before the Gregorian switch, r400: year modulo 400
  function automatic logic is_leap(logic [1:0] low2, logic early,
                                   logic [R400_W-1:0] r400);
    logic cent;
    cent = (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
    return (low2 == 2'd0) && (early || !cent);
  endfunction

endpackage

/* rtl/jdc_ctrl.sv */
// ----------------------------------------------------------------------------
// jdc_ctrl: sequencer for the Julian day converter
// Steps the datapath through encode or decode and flags the result word.
// ----------------------------------------------------------------------------
module jdc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           opcode_i,
  input  jdc_pkg::stat_t stat_i,
  output jdc_pkg::ctrl_t ctrl_o,
  output logic           busy_o
);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_E_BASE  = 13'b0000000000010,
    S_E_CENT  = 13'b0000000000100,
    S_E_LEAP  = 13'b0000000001000,
    S_E_MON   = 13'b0000000010000,
    S_E_FIN   = 13'b0000000100000,
    S_D_SHIFT = 13'b0000001000000,
    S_D_DIV   = 13'b0000010000000,
    S_D_REM   = 13'b0000100000000,
    S_D_QTR   = 13'b0001000000000,
    S_D_CENT  = 13'b0010000000000,
    S_D_YEAR  = 13'b0100000000000,
    S_D_SCAN  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    ctrl_o.cmd  = jdc_pkg::CMD_NOP;
    ctrl_o.emit = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.cmd = jdc_pkg::CMD_LOAD;
          state_d    = opcode_i ? S_D_SHIFT : S_E_BASE;
        end
      end
      S_E_BASE: begin
        ctrl_o.cmd = jdc_pkg::CMD_E_BASE;
        state_d    = S_E_CENT;
      end
      S_E_CENT: begin
        ctrl_o.cmd = jdc_pkg::CMD_E_CENT;
        state_d    = S_E_LEAP;
      end
      S_E_LEAP: begin
        ctrl_o.cmd = jdc_pkg::CMD_E_LEAP;
        state_d    = S_E_MON;
      end
      S_E_MON: begin
        ctrl_o.cmd = jdc_pkg::CMD_MON_ADD;
        if (stat_i.mon_last) begin
          state_d = S_E_FIN;
        end
      end
      S_E_FIN: begin
        ctrl_o.cmd  = jdc_pkg::CMD_E_FIN;
        ctrl_o.emit = 1'b1;
        state_d     = S_IDLE;
      end
      S_D_SHIFT: begin
        ctrl_o.cmd = jdc_pkg::CMD_D_SHIFT;
        state_d    = S_D_DIV;
      end
      S_D_DIV: begin
        ctrl_o.cmd = jdc_pkg::CMD_D_DIV;
        state_d    = S_D_REM;
      end
      S_D_REM: begin
        ctrl_o.cmd = jdc_pkg::CMD_D_REM;
        state_d    = S_D_QTR;
      end
      S_D_QTR: begin
        ctrl_o.cmd = jdc_pkg::CMD_D_QTR;
        state_d    = S_D_CENT;
      end
      S_D_CENT: begin
        ctrl_o.cmd = jdc_pkg::CMD_D_CENT;
        state_d    = S_D_YEAR;
      end
      S_D_YEAR: begin
        // step back one year until the day count turns positive
        if (stat_i.days_pos) begin
          ctrl_o.cmd = jdc_pkg::CMD_YEAR_FIX;
          state_d    = S_D_SCAN;
        end else begin
          ctrl_o.cmd = jdc_pkg::CMD_YEAR_STEP;
        end
      end
      S_D_SCAN: begin
        ctrl_o.cmd = jdc_pkg::CMD_MON_SCAN;
        if (stat_i.scan_done) begin
          ctrl_o.emit = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* rtl/jdc_dp.sv */
// ----------------------------------------------------------------------------
// jdc_dp: datapath of the Julian day converter
// Accumulator, year and day registers, reciprocal dividers, month scanner.
// ----------------------------------------------------------------------------
module jdc_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jdc_pkg::req_t  req_i,
  input  jdc_pkg::ctrl_t ctrl_i,
  output jdc_pkg::stat_t stat_o,
  output jdc_pkg::res_t  res_o,
  output logic           done_o
);

  logic [jdc_pkg::DAY_W-1:0]  day_q, day_d;
  logic [jdc_pkg::MON_W-1:0]  month_q, month_d;
  logic [jdc_pkg::MON_W-1:0]  kmax_q, kmax_d;
  logic [jdc_pkg::MON_W-1:0]  idx_q, idx_d;
  jdc_pkg::acc_t              acc_q, acc_d;
  jdc_pkg::yy_t               yr_q, yr_d;
  jdc_pkg::days_t             days_q, days_d;
  logic [jdc_pkg::Q365_W-1:0] q365_q, q365_d;
  logic [jdc_pkg::Q100_W-1:0] q100_q, q100_d;
  logic [jdc_pkg::R400_W-1:0] r400_q, r400_d;
  logic [jdc_pkg::DAY_W-1:0]  doy_q, doy_d;
  logic                       neg_q, neg_d;
  logic                       lp_q, lp_d;
  jdc_pkg::res_t              res_q, res_d;
  logic                       done_q;

  // Shared terms
  jdc_pkg::yy_t                   yr_inc;
  logic [jdc_pkg::R400_W-1:0]     r400_inc;
  logic [jdc_pkg::LEN_W-1:0]      len;
  logic                           fits;
  jdc_pkg::days_t                 days_less;
  jdc_pkg::acc_t                  abs_acc;
  logic [jdc_pkg::DN_W-1:0]       mag;
  logic [jdc_pkg::PROD365_W-1:0]  prod365;
  logic [jdc_pkg::DN_W-1:0]       rem_full;
  jdc_pkg::acc_t                  shifted;
  jdc_pkg::acc_t                  shifted_cut;
  jdc_pkg::acc_t                  enc_sum;
  logic                           yr_lp;
  jdc_pkg::res_t                  enc_res;
  jdc_pkg::res_t                  dec_res;

  always_comb begin
    yr_inc    = yr_q + jdc_pkg::yy_t'(1);
    r400_inc  = (r400_q == jdc_pkg::R400_W'(jdc_pkg::CYCLE_YEARS - 1)) ?
                '0 : r400_q + 1'b1;
    len       = jdc_pkg::month_len(lp_q, idx_q);
    fits      = (days_q <= jdc_pkg::days_t'(len));
    days_less = days_q - jdc_pkg::days_t'(len);
    abs_acc   = acc_q[jdc_pkg::ACC_W-1] ? -acc_q : acc_q;
    mag       = abs_acc[jdc_pkg::DN_W-1:0];
    prod365   = jdc_pkg::PROD365_W'(mag) * jdc_pkg::PROD365_W'(jdc_pkg::RECIP365);
    rem_full  = mag - jdc_pkg::DN_W'(jdc_pkg::DN_W'(q365_q) *
                                     jdc_pkg::DN_W'(jdc_pkg::YEAR_DAYS));
    shifted     = acc_q - jdc_pkg::acc_t'(jdc_pkg::JDN_SHIFT);
    shifted_cut = acc_q - jdc_pkg::acc_t'(jdc_pkg::JDN_SHIFT - jdc_pkg::CUT_DAYS);
    enc_sum   = (acc_q > jdc_pkg::acc_t'(jdc_pkg::CUT_LIMIT)) ?
                acc_q + jdc_pkg::acc_t'(jdc_pkg::JDN_SHIFT - jdc_pkg::CUT_DAYS) :
                acc_q + jdc_pkg::acc_t'(jdc_pkg::JDN_SHIFT);
    yr_lp     = jdc_pkg::is_leap(yr_q[1:0], yr_q < jdc_pkg::yy_t'(jdc_pkg::GREG_YEAR),
                                 r400_q);

    enc_res                = '0;
    enc_res.out_day_number = enc_sum[jdc_pkg::DN_W-1:0];

    dec_res                 = '0;
    dec_res.out_day         = fits ? days_q[jdc_pkg::ODAY_W-1:0] :
                                     days_less[jdc_pkg::ODAY_W-1:0];
    dec_res.out_month       = idx_q + 1'b1;
    dec_res.out_year        = yr_q[jdc_pkg::YEAR_W-1:0];
    dec_res.out_day_of_year = doy_q;
  end

  always_comb begin
    day_d   = day_q;
    month_d = month_q;
    kmax_d  = kmax_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    yr_d    = yr_q;
    days_d  = days_q;
    q365_d  = q365_q;
    q100_d  = q100_q;
    r400_d  = r400_q;
    doy_d   = doy_q;
    neg_d   = neg_q;
    lp_d    = lp_q;
    case (ctrl_i.cmd)
      jdc_pkg::CMD_LOAD: begin
        day_d   = req_i.in_day;
        month_d = req_i.in_month;
        kmax_d  = (req_i.in_month >= jdc_pkg::MON_W'(jdc_pkg::MONTH_CAP)) ?
                  jdc_pkg::MON_W'(jdc_pkg::MONTH_CAP - 1) : req_i.in_month - 1'b1;
        // encode works from the count of preceding years
        yr_d    = jdc_pkg::yy_t'(req_i.in_year) - jdc_pkg::yy_t'(1);
        acc_d   = jdc_pkg::acc_t'(req_i.in_day_number);
      end
      jdc_pkg::CMD_E_BASE: begin
        acc_d  = jdc_pkg::acc_t'(yr_q) * jdc_pkg::acc_t'(jdc_pkg::YEAR_DAYS) +
                 jdc_pkg::acc_t'(jdc_pkg::div4_trunc(yr_q));
        q100_d = jdc_pkg::div100(yr_q[jdc_pkg::DIV_IN_W-1:0]);
      end
      jdc_pkg::CMD_E_CENT: begin
        if (yr_q > jdc_pkg::yy_t'(jdc_pkg::GREG_YEAR)) begin
          acc_d = acc_q - jdc_pkg::acc_t'(q100_q) + jdc_pkg::acc_t'(q100_q >> 2) +
                  jdc_pkg::acc_t'(jdc_pkg::CENT_ADJ);
        end
        q100_d = jdc_pkg::div100(yr_inc[jdc_pkg::DIV_IN_W-1:0]);
      end
      jdc_pkg::CMD_E_LEAP: begin
        lp_d  = jdc_pkg::is_leap(yr_inc[1:0],
                                 yr_inc < jdc_pkg::yy_t'(jdc_pkg::GREG_YEAR),
                                 jdc_pkg::rem400(yr_inc[jdc_pkg::DIV_IN_W-1:0], q100_q));
        idx_d = '0;
      end
      jdc_pkg::CMD_MON_ADD: begin
        if (month_q == '0) begin
          acc_d = acc_q + jdc_pkg::acc_t'(day_q) - jdc_pkg::acc_t'(1);
        end else if (idx_q == kmax_q) begin
          acc_d = acc_q + jdc_pkg::acc_t'(day_q);
        end else begin
          acc_d = acc_q + jdc_pkg::acc_t'(len);
          idx_d = idx_q + 1'b1;
        end
      end
      jdc_pkg::CMD_D_SHIFT: begin
        acc_d = (shifted > jdc_pkg::acc_t'(jdc_pkg::CUT_LIMIT)) ? shifted_cut : shifted;
      end
      jdc_pkg::CMD_D_DIV: begin
        neg_d  = acc_q[jdc_pkg::ACC_W-1];
        q365_d = prod365[jdc_pkg::RECIP365_SH +: jdc_pkg::Q365_W];
      end
      jdc_pkg::CMD_D_REM: begin
        // truncate toward zero: quotient and remainder take the sign of the input
        yr_d   = neg_q ? -jdc_pkg::yy_t'(q365_q) : jdc_pkg::yy_t'(q365_q);
        days_d = neg_q ? -jdc_pkg::days_t'(rem_full[jdc_pkg::DAY_W-1:0]) :
                         jdc_pkg::days_t'(rem_full[jdc_pkg::DAY_W-1:0]);
      end
      jdc_pkg::CMD_D_QTR: begin
        days_d = days_q - jdc_pkg::days_t'(jdc_pkg::div4_trunc(yr_q));
        q100_d = jdc_pkg::div100(yr_q[jdc_pkg::DIV_IN_W-1:0]);
      end
      jdc_pkg::CMD_D_CENT: begin
        if (yr_q >= jdc_pkg::yy_t'(jdc_pkg::CENT_YEAR)) begin
          days_d = days_q + jdc_pkg::days_t'(q100_q) - jdc_pkg::days_t'(q100_q >> 2) -
                   jdc_pkg::days_t'(jdc_pkg::CENT_ADJ);
        end
        r400_d = jdc_pkg::rem400(yr_q[jdc_pkg::DIV_IN_W-1:0], q100_q);
      end
      jdc_pkg::CMD_YEAR_STEP: begin
        days_d = days_q + jdc_pkg::days_t'(jdc_pkg::YEAR_DAYS) + jdc_pkg::days_t'(yr_lp);
        yr_d   = yr_q - jdc_pkg::yy_t'(1);
        r400_d = (r400_q == '0) ? jdc_pkg::R400_W'(jdc_pkg::CYCLE_YEARS - 1) :
                                  r400_q - 1'b1;
      end
      jdc_pkg::CMD_YEAR_FIX: begin
        yr_d   = yr_inc;
        r400_d = r400_inc;
        lp_d   = jdc_pkg::is_leap(yr_inc[1:0],
                                  yr_inc < jdc_pkg::yy_t'(jdc_pkg::GREG_YEAR), r400_inc);
        idx_d  = '0;
        doy_d  = days_q[jdc_pkg::DAY_W-1:0];
      end
      jdc_pkg::CMD_MON_SCAN: begin
        if (!fits) begin
          days_d = days_less;
          if (idx_q != jdc_pkg::MON_W'(jdc_pkg::LAST_MONTH_IDX)) begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_d = res_q;
    if (ctrl_i.emit) begin
      res_d = (ctrl_i.cmd == jdc_pkg::CMD_E_FIN) ? enc_res : dec_res;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q   <= day_d;
    month_q <= month_d;
    kmax_q  <= kmax_d;
    idx_q   <= idx_d;
    acc_q   <= acc_d;
    yr_q    <= yr_d;
    days_q  <= days_d;
    q365_q  <= q365_d;
    q100_q  <= q100_d;
    r400_q  <= r400_d;
    doy_q   <= doy_d;
    neg_q   <= neg_d;
    lp_q    <= lp_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.emit;
    end
  end

  assign stat_o.mon_last  = (month_q == '0) || (idx_q == kmax_q);
  assign stat_o.days_pos  = (days_q > jdc_pkg::days_t'(0));
  assign stat_o.scan_done = fits || (idx_q == jdc_pkg::MON_W'(jdc_pkg::LAST_MONTH_IDX));
  assign res_o            = res_q;
  assign done_o           = done_q;

  // The year loop must leave a positive day count for the month scan
  a_scan_days_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.cmd == jdc_pkg::CMD_MON_SCAN) |-> (days_q > jdc_pkg::days_t'(0)))
    else $error("month scan started with non-positive day count");

  a_scan_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.cmd == jdc_pkg::CMD_MON_SCAN) |->
      (idx_q <= jdc_pkg::MON_W'(jdc_pkg::LAST_MONTH_IDX)))
    else $error("month scan index past December");

endmodule

/* rtl/julian_day_date_converter_core.sv */
// ----------------------------------------------------------------------------
// julian_day_date_converter_core: date <-> Julian day number converter
// A request word (opcode 0 encode, 1 decode) is taken at a clock edge where
// start is high and busy is low. One result word per request is flagged by
// done_o for exactly one cycle and stays on res_o until the next result; it
// cannot be held off, so capture it on that cycle. Encode keeps busy high
// through the base, century and leap steps, the month sum that adds one
// month length per cycle, and a final step. Decode keeps busy high through
// the shift, divide, remainder, quarter and century steps, then the year
// correction steps and the month scan steps, both running one step per
// cycle on the day register. done_o rises in the first cycle with
// busy low, and a new request may be started in that same cycle.
// ----------------------------------------------------------------------------
module julian_day_date_converter_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  jdc_pkg::req_t req_i,
  output jdc_pkg::res_t res_o,
  output logic          done_o
);

  jdc_pkg::ctrl_t ctrl;
  jdc_pkg::stat_t stat;

  jdc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (req_i.opcode),
    .stat_i   (stat),
    .ctrl_o   (ctrl),
    .busy_o   (busy)
  );

  jdc_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .res_o  (res_o),
    .done_o (done_o)
  );

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result word without a request in flight");

  a_busy_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("request finished without a result word");

  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result word repeated");

endmodule
